/* hdl/nmp_pkg.sv */
// Package for the notification message parser.
// Holds the sequencer states, result word layout, codes and byte helpers.
// No dependencies.
package nmp_pkg;

    localparam int OFF_W = 11;

    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_SENDER  = 2'd1;
    localparam logic [1:0] KIND_MESSAGE = 2'd2;

    localparam logic [2:0] ST_TEXT_OK   = 3'd0;
    localparam logic [2:0] ST_BIN_OK    = 3'd1;
    localparam logic [2:0] ST_BIN_TRUNC = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic [7:0]  BIN_MARK  = 8'h01;
    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  FULL_BYTE = 8'hFF;
    localparam logic [11:0] DUR_ON    = 12'd3000;
    localparam logic [OFF_W-1:0] BIN_MIN_LEN = 11'd9;
    localparam logic [OFF_W-1:0] FROM_MIN_LEN = 11'd6;

    typedef enum logic [4:0] {
        S_LOAD, S_WAIT,
        S_B_CC, S_B_R, S_B_G, S_B_B, S_B_VIB, S_B_TL, S_B_SCR,
        S_APP, S_MSG,
        S_T_PFX, S_T_SCAN, S_T_SND, S_T_WS,
        S_SUM
    } state_t;

    typedef enum logic [1:0] {
        MODE_BIN, MODE_PLAIN, MODE_FROM
    } mode_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [2:0]  status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] effect_time;
        logic [7:0]  vibration_mode;
        logic [7:0]  screen_fx;
        logic        last;
    } result_t;

    function automatic logic [7:0] app_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h41;
            default: c = 8'h70;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pfx_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h6F;
            3'd3:    c = 8'h6D;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

/* hdl/nmp_store.sv */
// Packet byte store: one write port, one read port with registered data.
// No dependencies.
module nmp_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/nmp_ctrl.sv */
// Load counter, parse sequencer and result register of the parser.
// Depends on nmp_pkg; reads the packet through nmp_store.
module nmp_ctrl #(
    parameter int PACKET_MAX  = 64,
    parameter int SENDER_MAX  = 16,
    parameter int MESSAGE_MAX = 48,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_byte,
    input  logic             s_last,
    output logic             m_valid,
    input  logic             m_ready,
    output nmp_pkg::result_t m_res,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output logic [7:0]       mem_wdata,
    output logic [AW-1:0]    mem_raddr,
    input  logic [7:0]       mem_rdata
);
    import nmp_pkg::*;

    localparam logic [OFF_W-1:0] PKT_LIM = OFF_W'(PACKET_MAX);
    localparam logic [OFF_W-1:0] SND_LIM = OFF_W'(SENDER_MAX);
    localparam logic [OFF_W-1:0] MSG_LIM = OFF_W'(MESSAGE_MAX - 1);
    localparam logic [CW-1:0]    SND_START = CW'(5);

    state_t state_reg, state_next, ret_reg, ret_next;
    mode_t  mode_reg, mode_next;
    logic [CW-1:0] len_reg, len_next, ptr_reg, ptr_next, end_reg, end_next;
    logic [CW-1:0] colon_reg, colon_next, lastns_reg, lastns_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [7:0] sum_reg, sum_next, first_reg, first_next;
    logic ovf_reg, ovf_next, hasns_reg, hasns_next, match_reg, match_next;
    logic [1:0] app_idx_reg, app_idx_next;
    logic [2:0] status_reg, status_next;
    logic [7:0] red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [11:0] dur_reg, dur_next;
    logic [7:0] vib_reg, vib_next, scr_reg, scr_next;
    logic mv_reg, mv_next;
    result_t res_reg, res_next, out_res;
    logic out_fire, s_fire, full;

    assign full      = (OFF_W'(len_reg) == PKT_LIM);
    assign s_fire    = s_valid && s_ready;
    assign mem_we    = s_fire && !full;
    assign mem_waddr = len_reg[AW-1:0];
    assign mem_wdata = s_byte;
    assign mem_raddr = ptr_reg[AW-1:0];
    assign m_valid   = mv_reg;
    assign m_res     = res_reg;

    // Output decode: handshake and the word offered in each emitting state.
    always_comb begin
        logic ofree;
        ofree    = !mv_reg || m_ready;
        s_ready  = (state_reg == S_LOAD);
        out_fire = 1'b0;
        out_res  = '0;
        unique case (state_reg)
            S_APP: begin
                out_fire     = ofree;
                out_res.kind = KIND_SENDER;
                out_res.ch   = app_char(app_idx_reg);
            end
            S_T_SND: begin
                out_fire     = ofree;
                out_res.kind = KIND_SENDER;
                out_res.ch   = mem_rdata;
            end
            S_MSG: begin
                out_fire     = ofree && (mem_rdata != 8'd0);
                out_res.kind = KIND_MESSAGE;
                out_res.ch   = mem_rdata;
            end
            S_SUM: begin
                out_fire               = ofree;
                out_res.kind           = KIND_SUMMARY;
                out_res.status         = status_reg;
                out_res.red            = red_reg;
                out_res.green          = green_reg;
                out_res.blue           = blue_reg;
                out_res.effect_time    = dur_reg;
                out_res.vibration_mode = vib_reg;
                out_res.screen_fx      = scr_reg;
                out_res.last           = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Next state and datapath.
    always_comb begin
        logic [OFF_W-1:0] lenx, rdx, o, plen;
        logic [CW-1:0] lenp1, rd_p, ws_p, wsd_p, p1, send_end;
        state_t rd_ret;
        logic do_read, do_plain, do_msgdone, do_ws, do_wsdone, do_after_app;
        logic [7:0] first_v;

        state_next = state_reg;  ret_next = ret_reg;  mode_next = mode_reg;
        len_next = len_reg;  ptr_next = ptr_reg;  end_next = end_reg;
        colon_next = colon_reg;  lastns_next = lastns_reg;  off_next = off_reg;
        sum_next = sum_reg;  first_next = first_reg;  ovf_next = ovf_reg;
        hasns_next = hasns_reg;  match_next = match_reg;  app_idx_next = app_idx_reg;
        status_next = status_reg;  red_next = red_reg;  green_next = green_reg;
        blue_next = blue_reg;  dur_next = dur_reg;  vib_next = vib_reg;
        scr_next = scr_reg;

        lenx  = OFF_W'(len_reg);
        rdx   = OFF_W'(mem_rdata);
        lenp1 = len_reg + CW'(1);
        plen  = lenx;
        o     = '0;
        rd_p = '0;  ws_p = '0;  wsd_p = '0;  p1 = ptr_reg + CW'(1);  send_end = '0;
        rd_ret = S_WAIT;
        do_read = 1'b0;  do_plain = 1'b0;  do_msgdone = 1'b0;
        do_ws = 1'b0;  do_wsdone = 1'b0;  do_after_app = 1'b0;
        first_v = (len_reg == '0) ? s_byte : first_reg;

        unique case (state_reg)
            S_LOAD: begin
                if (s_fire) begin
                    if (!full) begin
                        len_next   = lenp1;
                        sum_next   = sum_reg + s_byte;
                        first_next = first_v;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        red_next = '0;  green_next = '0;  blue_next = '0;
                        dur_next = '0;  vib_next = '0;  scr_next = '0;
                        if (ovf_reg || full) begin
                            status_next = ST_OVERFLOW;
                            state_next  = S_SUM;
                        end else if (OFF_W'(lenp1) >= BIN_MIN_LEN && first_v == BIN_MARK
                                     && s_byte == sum_reg) begin
                            mode_next   = MODE_BIN;
                            status_next = ST_BIN_TRUNC;
                            do_read = 1'b1;  rd_p = CW'(4);  rd_ret = S_B_CC;
                        end else begin
                            status_next = ST_TEXT_OK;
                            red_next = FULL_BYTE;  green_next = FULL_BYTE;
                            blue_next = FULL_BYTE;  dur_next = DUR_ON;
                            vib_next = 8'd1;
                            if (OFF_W'(lenp1) > FROM_MIN_LEN) begin
                                match_next = 1'b1;
                                do_read = 1'b1;  rd_p = '0;  rd_ret = S_T_PFX;
                            end else begin
                                do_plain = 1'b1;
                                plen = OFF_W'(lenp1);
                            end
                        end
                    end
                end
            end
            S_WAIT: state_next = ret_reg;
            S_B_CC: begin
                o = OFF_W'(5) + rdx * OFF_W'(3);
                if (o > lenx) begin
                    state_next = S_SUM;
                end else begin
                    off_next = o;
                    if (mem_rdata != 8'd0) begin
                        do_read = 1'b1;  rd_p = CW'(5);  rd_ret = S_B_R;
                    end else if (o + OFF_W'(2) > lenx) begin
                        state_next = S_SUM;
                    end else begin
                        do_read = 1'b1;  rd_p = o[CW-1:0];  rd_ret = S_B_VIB;
                    end
                end
            end
            S_B_R: begin
                red_next = mem_rdata;
                do_read = 1'b1;  rd_p = CW'(6);  rd_ret = S_B_G;
            end
            S_B_G: begin
                green_next = mem_rdata;
                do_read = 1'b1;  rd_p = CW'(7);  rd_ret = S_B_B;
            end
            S_B_B: begin
                blue_next = mem_rdata;
                dur_next  = DUR_ON;
                if (off_reg + OFF_W'(2) > lenx) begin
                    state_next = S_SUM;
                end else begin
                    do_read = 1'b1;  rd_p = off_reg[CW-1:0];  rd_ret = S_B_VIB;
                end
            end
            S_B_VIB: begin
                vib_next = mem_rdata;
                o = off_reg + OFF_W'(2);
                if (o + OFF_W'(1) > lenx) begin
                    state_next = S_SUM;
                end else begin
                    off_next = o;
                    do_read = 1'b1;  rd_p = o[CW-1:0];  rd_ret = S_B_TL;
                end
            end
            S_B_TL: begin
                o = off_reg + OFF_W'(1);
                if (o + rdx > lenx) begin
                    // The text runs past the end: only the status survives.
                    vib_next = '0;  red_next = '0;  green_next = '0;
                    blue_next = '0;  dur_next = '0;
                    state_next = S_SUM;
                end else begin
                    status_next  = ST_BIN_OK;
                    ptr_next     = o[CW-1:0];
                    end_next     = CW'(o + ((rdx > MSG_LIM) ? MSG_LIM : rdx));
                    off_next     = o + rdx;
                    app_idx_next = '0;
                    state_next   = S_APP;
                end
            end
            S_B_SCR: begin
                scr_next   = mem_rdata;
                state_next = S_SUM;
            end
            S_APP: begin
                if (out_fire) begin
                    if (app_idx_reg == 2'd2) begin
                        do_after_app = 1'b1;
                    end else begin
                        app_idx_next = app_idx_reg + 2'd1;
                    end
                end
            end
            S_MSG: begin
                if (mem_rdata == 8'd0) begin
                    do_msgdone = 1'b1;
                end else if (out_fire) begin
                    if (p1 == end_reg) begin
                        do_msgdone = 1'b1;
                    end else begin
                        do_read = 1'b1;  rd_p = p1;  rd_ret = S_MSG;
                    end
                end
            end
            S_T_PFX: begin
                if (ptr_reg == CW'(4)) begin
                    if (match_reg && to_lower(mem_rdata) == pfx_char(ptr_reg[2:0])) begin
                        hasns_next = 1'b0;
                        do_read = 1'b1;  rd_p = SND_START;  rd_ret = S_T_SCAN;
                    end else begin
                        do_plain = 1'b1;
                    end
                end else begin
                    match_next = match_reg && (to_lower(mem_rdata) == pfx_char(ptr_reg[2:0]));
                    do_read = 1'b1;  rd_p = p1;  rd_ret = S_T_PFX;
                end
            end
            S_T_SCAN: begin
                if (mem_rdata == 8'd0) begin
                    do_plain = 1'b1;
                end else if (mem_rdata == CH_COLON) begin
                    mode_next  = MODE_FROM;
                    colon_next = ptr_reg;
                    o = OFF_W'(ptr_reg - SND_START);
                    if (o != '0 && o < SND_LIM) begin
                        send_end = hasns_reg ? lastns_reg + CW'(1) : SND_START;
                        if (send_end == SND_START) begin
                            do_ws = 1'b1;  ws_p = p1;
                        end else begin
                            end_next = send_end;
                            do_read = 1'b1;  rd_p = SND_START;  rd_ret = S_T_SND;
                        end
                    end else begin
                        ptr_next     = p1;
                        app_idx_next = '0;
                        state_next   = S_APP;
                    end
                end else begin
                    if (mem_rdata != CH_SPACE) begin
                        lastns_next = ptr_reg;
                        hasns_next  = 1'b1;
                    end
                    if (p1 == len_reg) begin
                        do_plain = 1'b1;
                    end else begin
                        do_read = 1'b1;  rd_p = p1;  rd_ret = S_T_SCAN;
                    end
                end
            end
            S_T_SND: begin
                if (out_fire) begin
                    if (p1 == end_reg) begin
                        do_ws = 1'b1;  ws_p = colon_reg + CW'(1);
                    end else begin
                        do_read = 1'b1;  rd_p = p1;  rd_ret = S_T_SND;
                    end
                end
            end
            S_T_WS: begin
                if (is_ws(mem_rdata)) begin
                    if (p1 < len_reg) begin
                        do_read = 1'b1;  rd_p = p1;  rd_ret = S_T_WS;
                    end else begin
                        do_wsdone = 1'b1;  wsd_p = p1;
                    end
                end else begin
                    do_wsdone = 1'b1;  wsd_p = ptr_reg;
                end
            end
            S_SUM: begin
                if (out_fire) begin
                    len_next   = '0;
                    sum_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase

        if (do_after_app) begin
            if (mode_reg == MODE_FROM) begin
                do_ws = 1'b1;  ws_p = ptr_reg;
            end else if (ptr_reg == end_reg) begin
                do_msgdone = 1'b1;
            end else begin
                do_read = 1'b1;  rd_p = ptr_reg;  rd_ret = S_MSG;
            end
        end
        if (do_ws) begin
            if (ws_p < len_reg) begin
                do_read = 1'b1;  rd_p = ws_p;  rd_ret = S_T_WS;
            end else begin
                do_wsdone = 1'b1;  wsd_p = ws_p;
            end
        end
        if (do_wsdone) begin
            o = OFF_W'(len_reg - wsd_p);
            if (o != '0 && o <= MSG_LIM) begin
                end_next = len_reg;
                do_read = 1'b1;  rd_p = wsd_p;  rd_ret = S_MSG;
            end else begin
                state_next = S_SUM;
            end
        end
        if (do_msgdone) begin
            if (mode_reg == MODE_BIN && off_reg < lenx) begin
                do_read = 1'b1;  rd_p = off_reg[CW-1:0];  rd_ret = S_B_SCR;
            end else begin
                state_next = S_SUM;
            end
        end
        if (do_plain) begin
            mode_next    = MODE_PLAIN;
            ptr_next     = '0;
            end_next     = CW'((plen > MSG_LIM) ? MSG_LIM : plen);
            app_idx_next = '0;
            state_next   = S_APP;
        end
        if (do_read) begin
            ptr_next   = rd_p;
            ret_next   = rd_ret;
            state_next = S_WAIT;
        end

        mv_next  = mv_reg;
        res_next = res_reg;
        if (out_fire) begin
            mv_next  = 1'b1;
            res_next = out_res;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            len_reg   <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg     <= ret_next;     mode_reg    <= mode_next;
        ptr_reg     <= ptr_next;     end_reg     <= end_next;
        colon_reg   <= colon_next;   lastns_reg  <= lastns_next;
        off_reg     <= off_next;     first_reg   <= first_next;
        hasns_reg   <= hasns_next;   match_reg   <= match_next;
        app_idx_reg <= app_idx_next; status_reg  <= status_next;
        red_reg     <= red_next;     green_reg   <= green_next;
        blue_reg    <= blue_next;    dur_reg     <= dur_next;
        vib_reg     <= vib_next;     scr_reg     <= scr_next;
        res_reg     <= res_next;
    end

endmodule

/* hdl/notification_message_parser.sv */
// Top level of the notification message parser.
// Depends on nmp_pkg, nmp_store and nmp_ctrl.
//
// Bytes of a packet are accepted one per cycle and stored until the word
// marked with s_tlast; the packet is then parsed by a sequencer that reads
// the store through its single registered read port and emits sender
// characters, message characters and a closing summary word (m_tlast high).
// Every store read passes through the S_WAIT state, and each stored byte is
// read at most twice (once while the text form is checked, once when it is
// copied out); a receiver stall of the output register also holds up the
// parse. Input is not accepted from the last byte of a packet until its
// summary word has entered the output register. An overflowed packet goes
// straight to its summary.
module notification_message_parser #(
    parameter int PACKET_MAX  = 64,
    parameter int SENDER_MAX  = 16,
    parameter int MESSAGE_MAX = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[1:0], ch[9:2], status[12:10], red[20:13], green[28:21],
    // blue[36:29], effect_time[48:37], vibration_mode[56:49],
    // screen_fx[64:57], zero fill to 72 bits
    output logic [71:0] m_tdata,
    output logic        m_tlast    // last
);
    import nmp_pkg::*;

    localparam int AW = $clog2(PACKET_MAX);
    localparam int CW = $clog2(PACKET_MAX + 1);

    result_t       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    nmp_store #(
        .DEPTH(PACKET_MAX),
        .AW   (AW)
    ) u_store (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    nmp_ctrl #(
        .PACKET_MAX (PACKET_MAX),
        .SENDER_MAX (SENDER_MAX),
        .MESSAGE_MAX(MESSAGE_MAX),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_byte   (s_tdata),
        .s_last   (s_tlast),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (res),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    assign m_tdata = {7'd0, res.screen_fx, res.vibration_mode, res.effect_time,
                      res.blue, res.green, res.red, res.status, res.ch, res.kind};
    assign m_tlast = res.last;

endmodule

/* bench/nmp_checker.sv */
// Checker for the notification message parser.
// Watches the byte and result channels, predicts each packet's result words
// and compares them in order. Depends on nmp_pkg.
`timescale 1ns / 1ps

module nmp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_words
);
    import nmp_pkg::*;

    localparam int PKT_MAX = 64;
    localparam int SND_MAX = 16;
    localparam int MSG_MAX = 48;

    logic [7:0] pkt_bytes [PKT_MAX];
    int         pkt_len;
    logic [7:0] pkt_sum;
    logic       pkt_over;
    result_t    expected_words [$];

    assign pending_words = expected_words.size();

    function automatic logic [7:0] lower_ch(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic space_ch(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic result_t char_word(input logic [1:0] k, input logic [7:0] c);
        result_t r;
        r = '0;
        r.kind = k;
        r.ch = c;
        return r;
    endfunction

    function automatic result_t sum_word(input logic [2:0] st, input logic [7:0] rd,
                                         input logic [7:0] gr, input logic [7:0] bl,
                                         input logic [11:0] du, input logic [7:0] vb,
                                         input logic [7:0] sc);
        result_t r;
        r = '0;
        r.kind = KIND_SUMMARY;
        r.status = st;
        r.red = rd;
        r.green = gr;
        r.blue = bl;
        r.effect_time = du;
        r.vibration_mode = vb;
        r.screen_fx = sc;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic push_app();
        expected_words.push_back(char_word(KIND_SENDER, 8'h41));
        expected_words.push_back(char_word(KIND_SENDER, 8'h70));
        expected_words.push_back(char_word(KIND_SENDER, 8'h70));
    endtask

    // Message characters stop at the first zero byte.
    task automatic push_message(input int start, input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if (pkt_bytes[start + i] == 8'h00) break;
            expected_words.push_back(char_word(KIND_MESSAGE, pkt_bytes[start + i]));
        end
    endtask

    task automatic predict_packet(input int len, input logic [7:0] sum_before);
        logic [7:0] f;
        logic       texty, matched, found;
        int off, cc, tl, cp, colon, n, sl, ms, i;
        logic [7:0] rd, gr, bl, vb, sc;
        logic [11:0] du;
        f = pkt_bytes[0];
        texty = (f >= 8'h20 && f < 8'h7F) || f >= 8'hC0;
        if (!texty && len >= 9 && pkt_bytes[len-1] == sum_before && f == BIN_MARK) begin
            cc = pkt_bytes[4];
            off = 5;
            rd = 0; gr = 0; bl = 0; du = 0; sc = 0;
            if (off + cc * 3 > len) begin
                expected_words.push_back(sum_word(ST_BIN_TRUNC, 0, 0, 0, 0, 0, 0));
                return;
            end
            if (cc > 0) begin
                rd = pkt_bytes[5]; gr = pkt_bytes[6]; bl = pkt_bytes[7]; du = DUR_ON;
            end
            off += cc * 3;
            if (off + 2 > len) begin
                expected_words.push_back(sum_word(ST_BIN_TRUNC, rd, gr, bl, du, 0, 0));
                return;
            end
            vb = pkt_bytes[off];
            off += 2;
            if (off + 1 > len) begin
                expected_words.push_back(sum_word(ST_BIN_TRUNC, rd, gr, bl, du, vb, 0));
                return;
            end
            tl = pkt_bytes[off];
            off++;
            if (off + tl > len) begin
                expected_words.push_back(sum_word(ST_BIN_TRUNC, 0, 0, 0, 0, 0, 0));
                return;
            end
            cp = tl > MSG_MAX - 1 ? MSG_MAX - 1 : tl;
            push_app();
            push_message(off, cp);
            off += tl;
            if (off < len) sc = pkt_bytes[off];
            expected_words.push_back(sum_word(ST_BIN_OK, rd, gr, bl, du, vb, sc));
            return;
        end
        if (len > 6) begin
            matched = lower_ch(pkt_bytes[0]) == 8'h66 && lower_ch(pkt_bytes[1]) == 8'h72 &&
                      lower_ch(pkt_bytes[2]) == 8'h6F && lower_ch(pkt_bytes[3]) == 8'h6D &&
                      pkt_bytes[4] == 8'h20;
            found = 1'b0;
            colon = 0;
            if (matched) begin
                for (i = 5; i < len; i++) begin
                    if (pkt_bytes[i] == 8'h00) break;
                    if (pkt_bytes[i] == CH_COLON) begin
                        colon = i;
                        found = 1'b1;
                        break;
                    end
                end
            end
            if (found) begin
                n = colon - 5;
                if (n > 0 && n < SND_MAX) begin
                    sl = n;
                    while (sl > 0 && pkt_bytes[5 + sl - 1] == CH_SPACE) sl--;
                    for (i = 0; i < sl; i++) begin
                        if (pkt_bytes[5 + i] == 8'h00) break;
                        expected_words.push_back(char_word(KIND_SENDER, pkt_bytes[5 + i]));
                    end
                end else begin
                    push_app();
                end
                ms = colon + 1;
                while (ms < len && space_ch(pkt_bytes[ms])) ms++;
                n = len - ms;
                if (n > 0 && n < MSG_MAX) push_message(ms, n);
                expected_words.push_back(sum_word(ST_TEXT_OK, 8'hFF, 8'hFF, 8'hFF,
                                                  DUR_ON, 8'd1, 8'd0));
                return;
            end
        end
        push_app();
        push_message(0, len > MSG_MAX - 1 ? MSG_MAX - 1 : len);
        expected_words.push_back(sum_word(ST_TEXT_OK, 8'hFF, 8'hFF, 8'hFF, DUR_ON, 8'd1, 8'd0));
    endtask

    task automatic report_mismatch(input string what, input logic [71:0] got,
                                   input logic [71:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        logic [7:0] sum_before;
        result_t got, want;
        if (!aresetn) begin
            pkt_len <= 0;
            pkt_sum <= 0;
            pkt_over <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                sum_before = pkt_sum;
                if (pkt_len < PKT_MAX) pkt_bytes[pkt_len] = s_tdata;
                if (s_tlast) begin
                    if (pkt_over || pkt_len >= PKT_MAX)
                        expected_words.push_back(sum_word(ST_OVERFLOW, 0, 0, 0, 0, 0, 0));
                    else
                        predict_packet(pkt_len + 1, sum_before);
                    pkt_len <= 0;
                    pkt_sum <= 0;
                    pkt_over <= 0;
                end else if (pkt_len < PKT_MAX) begin
                    pkt_len <= pkt_len + 1;
                    pkt_sum <= pkt_sum + s_tdata;
                end else begin
                    pkt_over <= 1'b1;
                end
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(0);
                got.kind = m_tdata[1:0];
                got.ch = m_tdata[9:2];
                got.status = m_tdata[12:10];
                got.red = m_tdata[20:13];
                got.green = m_tdata[28:21];
                got.blue = m_tdata[36:29];
                got.effect_time = m_tdata[48:37];
                got.vibration_mode = m_tdata[56:49];
                got.screen_fx = m_tdata[64:57];
                got.last = m_tlast;
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (got != want) report_mismatch("word", 72'(got), 72'(want));
                    if (m_tdata[71:65] != 7'd0)
                        report_mismatch("fill", 72'(m_tdata[71:65]), '0);
                end
            end
        end
    end

endmodule

/* bench/testbench.sv */
// Top of the notification message parser bench: clock, reset, packet stimulus.
// Depends on nmp_pkg, notification_message_parser and nmp_checker.
`timescale 1ns / 1ps

module testbench;
    import nmp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending_words;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          byte_total;
    logic [7:0]  pkt [$];

    notification_message_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    nmp_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_words(pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("[notification_message_parser] ERROR");
        $finish;
    end

    // Receiver: random stalls, or a long counted hold-off when requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Sends the queued packet, last byte marked; idles at random between words.
    task automatic send_packet();
        int i;
        for (i = 0; i < pkt.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= pkt[i];
            s_tlast <= (i == pkt.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            byte_total++;
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
    endtask

    task automatic put_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++) pkt.push_back(txt[i]);
    endtask

    // Appends the mod-256 sum of the packet so far.
    task automatic close_binary();
        logic [7:0] s;
        s = 0;
        foreach (pkt[i]) s += pkt[i];
        pkt.push_back(s);
    endtask

    task automatic make_binary(input int cc, input int tl, input logic scr, input logic good);
        int i;
        pkt = {};
        pkt.push_back(BIN_MARK);
        repeat (3) pkt.push_back(8'($urandom));
        pkt.push_back(8'(cc));
        repeat (cc * 3) pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        pkt.push_back(8'(tl));
        for (i = 0; i < tl; i++)
            pkt.push_back($urandom_range(9) == 0 ? 8'h00 : 8'($urandom));
        if (scr) pkt.push_back(8'($urandom));
        close_binary();
        if (!good) pkt[pkt.size() - 1] ^= 8'h5A;
    endtask

    task automatic make_from();
        int n, i;
        string pfx;
        pfx = $urandom_range(1) ? "From " : "fROM ";
        pkt = {};
        put_text(pfx);
        n = $urandom_range(18);
        for (i = 0; i < n; i++)
            pkt.push_back($urandom_range(4) == 0 ? CH_SPACE : 8'(8'h41 + $urandom_range(25)));
        pkt.push_back(CH_COLON);
        repeat ($urandom_range(3)) pkt.push_back($urandom_range(1) ? 8'h20 : 8'h09);
        n = $urandom_range(7) == 0 ? $urandom_range(44, 55) : $urandom_range(20);
        for (i = 0; i < n && pkt.size() < 64; i++)
            pkt.push_back($urandom_range(15) == 0 ? 8'h00 : 8'($urandom));
        if (pkt.size() < 7) pkt.push_back(8'h61);
    endtask

    task automatic make_noise(input int len);
        pkt = {};
        repeat (len) pkt.push_back(8'($urandom));
    endtask

    // Waits past the accept edge so the last packet's prediction is queued.
    task automatic wait_drained();
        repeat (2) @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic random_packet();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35) make_binary($urandom_range(6) == 0 ? 0 : $urandom_range(1, 3),
                                  $urandom_range(5) == 0 ? $urandom_range(47, 50)
                                                         : $urandom_range(12),
                                  1'($urandom_range(1)), $urandom_range(9) != 0);
        else if (sel < 70) make_from();
        else if (sel < 90) make_noise($urandom_range(1, 12));
        else if (sel < 95) make_noise($urandom_range(60, 70));
        else begin
            make_binary($urandom_range(3), $urandom_range(10), 1'b0, 1'b1);
            pkt[4] = 8'($urandom_range(4, 200));
            pkt.delete(pkt.size() - 1);
            close_binary();
        end
        send_packet();
    endtask

    initial begin
        int phase, k;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        byte_total = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed packets: single bytes, text forms, binary edge cases, overflow.
        make_noise(1); pkt[0] = 8'h00; send_packet();
        make_noise(1); pkt[0] = 8'hFF; send_packet();
        pkt = {}; put_text("From Bob: hi"); send_packet();
        pkt = {}; put_text("FROM   :  x"); send_packet();
        pkt = {}; put_text("from abcdefghijklmnopq: y"); send_packet();
        pkt = {}; put_text("From Al:   "); send_packet();
        make_binary(1, 4, 1'b1, 1'b1); send_packet();
        make_binary(0, 3, 1'b0, 1'b1); send_packet();
        make_binary(1, 50, 1'b0, 1'b1); send_packet();
        make_binary(1, 2, 1'b0, 1'b0); send_packet();
        make_binary(1, 2, 1'b0, 1'b1); pkt[8+2] = 8'd60;
        pkt.delete(pkt.size() - 1); close_binary(); send_packet();
        make_noise(66); send_packet();
        make_noise(64); send_packet();
        wait_drained();

        // Fill-up: hold the receiver off while a long packet is parsed and more arrive.
        hold_cycles = 600;
        make_noise(20); foreach (pkt[i]) pkt[i] = 8'(8'h41 + i % 26); send_packet();
        make_from(); send_packet();
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 79 : 33) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 79 : 33) : 0;
            for (k = 0; k < 2; k++)
                random_packet();
            while (byte_total < 430 * (phase + 1) / 4) random_packet();
            wait_drained();
        end

        if (fail_count == 0 && pending_words == 0)
            $display("[notification_message_parser] OK");
        else
            $display("[notification_message_parser] ERROR");
        $finish;
    end

endmodule
